>>> hdl/gfdt_pkg.sv
// Shared types and constants for the Gouraud fragment depth-test core.
// Holds field widths, configuration register indexes and depth constants.
// Used by the channel interfaces and the top level.
package gfdt_pkg;

  // Field widths
  localparam int unsigned POS_W    = 16;
  localparam int unsigned COV_W    = 8;
  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned COLOR_W  = 32;
  localparam int unsigned VDEPTH_W = 30;
  localparam int unsigned ZDEPTH_W = 32;

  // Depth store geometry
  localparam int unsigned ZADDR_W   = 16;
  localparam int unsigned ZENTRIES  = 65536;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_V0  = 3'd0,
    CFG_COLOR_V1  = 3'd1,
    CFG_COLOR_V2  = 3'd2,
    CFG_DEPTH_V0  = 3'd3,
    CFG_DEPTH_V1  = 3'd4,
    CFG_DEPTH_V2  = 3'd5,
    CFG_DEPTH_ON  = 3'd6
  } cfg_idx_t;

  // 10000.0 in 16.16, removed from every interpolated depth
  localparam logic signed [34:0] DEPTH_OFFSET = 35'sd655360000;
  localparam logic signed [34:0] Z_MAX = 35'sd2147483647;
  localparam logic signed [34:0] Z_MIN = -35'sd2147483648;

endpackage

>>> hdl/gfdt_frag_if.sv
// Fragment request channel: valid/ready handshake with the fragment fields.
// Depends on gfdt_pkg for the field widths.
interface gfdt_frag_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [gfdt_pkg::POS_W-1:0]    frag_x;
  logic signed [gfdt_pkg::POS_W-1:0]    frag_y;
  logic [gfdt_pkg::COV_W-1:0]           coverage;
  logic [gfdt_pkg::WEIGHT_W-1:0]        weight_a;
  logic [gfdt_pkg::WEIGHT_W-1:0]        weight_b;
  logic [gfdt_pkg::WEIGHT_W-1:0]        weight_c;

  modport source (output valid, frag_x, frag_y, coverage, weight_a, weight_b, weight_c,
                  input ready);
  modport sink   (input valid, frag_x, frag_y, coverage, weight_a, weight_b, weight_c,
                  output ready);
endinterface

// Pixel request channel: valid/ready handshake with position and colour.
// Depends on gfdt_pkg for the field widths.
interface gfdt_pixel_if;
  logic                              valid;
  logic                              ready;
  logic [gfdt_pkg::PIX_W-1:0]        pixel_x;
  logic [gfdt_pkg::PIX_W-1:0]        pixel_y;
  logic [gfdt_pkg::COLOR_W-1:0]      pixel_color;

  modport source (output valid, pixel_x, pixel_y, pixel_color, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, output ready);
endinterface

>>> hdl/gfdt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependencies.
module gfdt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/gouraud_fragment_depth_test_core.sv
// Gouraud fragment shading with a depth test against a 65536-entry depth store.
// Depends on gfdt_pkg, gfdt_frag_if / gfdt_pixel_if and gfdt_ram.
//
// Usage:
//   frag  : fragment requests (position, coverage, three Q1.16 weights).
//   pixel : shaded pixel requests (x, y, packed colour); zero or one per fragment.
//   cfg_* : register writes (vertex colours, vertex depths, depth-test enable),
//           taken at any edge with cfg_we high; write only while the core is idle.
// After acceptance an on-screen fragment steps through ST_MUL0, ST_MUL1 and
//   ST_MUL2 on the shared 30x18 depth multiplier, ST_SUM (accumulate),
//   ST_ZCALC (saturate) and ST_CMP (depth compare and store write), where its
//   pixel request, if any, is loaded. An off-screen fragment is dropped in its
//   acceptance cycle and the core is ready again at once. One fragment is in
//   flight at a time: no new fragment is taken until the current one leaves ST_CMP.
// Reset: rst clears the control state and starts a clearing pass that writes
//   zero to all 65536 depth entries, one per cycle; frag.ready stays low until
//   the pass ends. Register writes are taken during the pass.
// Stall: the pixel request sits in an output register; a new fragment is taken
//   while it waits, and the core holds in its compare step only if the output
//   register is still full when the next result is due.
module gouraud_fragment_depth_test_core #(
  parameter int unsigned SCREEN_WIDTH  = 256,
  parameter int unsigned SCREEN_HEIGHT = 256
) (
  input  logic                               clk,
  input  logic                               rst,
  gfdt_frag_if.sink                          frag,
  gfdt_pixel_if.source                       pixel,
  input  logic                               cfg_we,
  input  logic [gfdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfdt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned IDX_FULL_W = 25;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SUM,
    ST_ZCALC,
    ST_CMP
  } state_t;

  // Configuration registers
  logic [gfdt_pkg::COLOR_W-1:0]         color_v [3];
  logic signed [gfdt_pkg::VDEPTH_W-1:0] depth_v [3];
  logic                                 depth_test_on;

  // Control and datapath registers
  state_t                               state;
  logic [gfdt_pkg::ZADDR_W-1:0]         clr_addr;
  logic [gfdt_pkg::PIX_W-1:0]           x_r;
  logic [gfdt_pkg::PIX_W-1:0]           y_r;
  logic [gfdt_pkg::COV_W-1:0]           cov_r;
  logic [gfdt_pkg::WEIGHT_W-1:0]        w_r [3];
  logic [gfdt_pkg::ZADDR_W-1:0]         idx_r;
  logic [8:0]                           q_r [3];
  logic [7:0]                           chan_r [4];
  logic [gfdt_pkg::COLOR_W-1:0]         rgba_r;
  logic signed [47:0]                   prod;
  logic signed [49:0]                   acc;
  logic signed [gfdt_pkg::ZDEPTH_W-1:0] z_r;
  logic                                 out_valid;
  logic [gfdt_pkg::PIX_W-1:0]           out_x;
  logic [gfdt_pkg::PIX_W-1:0]           out_y;
  logic [gfdt_pkg::COLOR_W-1:0]         out_color;

  // Combinational signals
  logic                                 accept;
  logic                                 on_screen;
  logic [IDX_FULL_W-1:0]                idx_full;
  logic signed [gfdt_pkg::VDEPTH_W-1:0] mul_a;
  logic [gfdt_pkg::WEIGHT_W-1:0]        mul_w;
  logic [24:0]                          w255 [3];
  logic [11:0]                          chan_sum [4];
  logic [16:0]                          alpha_prod;
  logic signed [49:0]                   prod_ext;
  logic signed [34:0]                   z_wide;
  logic [gfdt_pkg::ZDEPTH_W-1:0]        rd_depth;
  logic                                 slot_free;
  logic                                 z_pass;
  logic                                 finish;
  logic                                 ram_we;
  logic [gfdt_pkg::ZADDR_W-1:0]         ram_waddr;
  logic [gfdt_pkg::ZDEPTH_W-1:0]        ram_wdata;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        color_v[i] <= '0;
        depth_v[i] <= '0;
      end
      depth_test_on <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gfdt_pkg::CFG_COLOR_V0: color_v[0] <= cfg_wdata;
        gfdt_pkg::CFG_COLOR_V1: color_v[1] <= cfg_wdata;
        gfdt_pkg::CFG_COLOR_V2: color_v[2] <= cfg_wdata;
        gfdt_pkg::CFG_DEPTH_V0: depth_v[0] <= cfg_wdata[gfdt_pkg::VDEPTH_W-1:0];
        gfdt_pkg::CFG_DEPTH_V1: depth_v[1] <= cfg_wdata[gfdt_pkg::VDEPTH_W-1:0];
        gfdt_pkg::CFG_DEPTH_V2: depth_v[2] <= cfg_wdata[gfdt_pkg::VDEPTH_W-1:0];
        gfdt_pkg::CFG_DEPTH_ON: depth_test_on <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Accept a request only when idle; drop it at once when off screen
  assign frag.ready = (state == ST_IDLE);
  assign accept     = frag.valid && frag.ready;
  assign on_screen  = !frag.frag_x[15] && (frag.frag_x[14:0] < 15'(SCREEN_WIDTH)) &&
                      !frag.frag_y[15] && (frag.frag_y[14:0] < 15'(SCREEN_HEIGHT));
  assign idx_full   = 25'(frag.frag_y[11:0]) * 25'(SCREEN_WIDTH) + 25'(frag.frag_x[11:0]);

  // Select the depth multiplier operands for each step
  always_comb begin
    unique case (state)
      ST_MUL1: begin
        mul_a = depth_v[1];
        mul_w = w_r[1];
      end
      ST_MUL2: begin
        mul_a = depth_v[2];
        mul_w = w_r[2];
      end
      default: begin
        mul_a = depth_v[0];
        mul_w = w_r[0];
      end
    endcase
  end

  // Colour math: weight reduction, channel sums (saturated where registered), alpha scale
  always_comb begin
    for (int v = 0; v < 3; v++) begin
      w255[v] = {w_r[v], 8'b0} - 25'(w_r[v]);
    end
    for (int ch = 0; ch < 4; ch++) begin
      chan_sum[ch] = '0;
      for (int v = 0; v < 3; v++) begin
        chan_sum[ch] = chan_sum[ch] +
          12'((18'(color_v[v][8*ch +: 8]) * (18'(q_r[v]) + 18'd1)) >> 8);
      end
    end
    alpha_prod = 17'(chan_r[3]) * (17'(cov_r) + 17'd1);
  end

  // Depth: sign-extend product, floor-shift, remove offset
  assign prod_ext = {{2{prod[47]}}, prod};
  assign z_wide   = 35'($signed(acc[49:16])) - gfdt_pkg::DEPTH_OFFSET;
  assign z_pass   = z_r < $signed(rd_depth);
  assign slot_free = !out_valid || pixel.ready;
  assign finish   = (state == ST_CMP) && slot_free;

  // Store port: clearing pass, else the depth update of a passing fragment
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = finish && depth_test_on && z_pass;
      ram_waddr = idx_r;
      ram_wdata = z_r;
    end
  end

  gfdt_ram #(
    .WIDTH(gfdt_pkg::ZDEPTH_W),
    .DEPTH(gfdt_pkg::ZENTRIES)
  ) u_zstore (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(idx_full[gfdt_pkg::ZADDR_W-1:0]),
    .rdata(rd_depth)
  );

  // Sequence one fragment through the shared multiplier, test and output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load the output register on a passing fragment, else free it on a take
      if (finish && (!depth_test_on || z_pass)) begin
        out_valid <= 1'b1;
      end else if (pixel.valid && pixel.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == gfdt_pkg::ZADDR_W'(gfdt_pkg::ZENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && on_screen) begin
            state <= ST_MUL0;
          end
        end
        ST_MUL0: begin
          for (int v = 0; v < 3; v++) begin
            q_r[v] <= w255[v][24:16];
          end
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          for (int ch = 0; ch < 4; ch++) begin
            chan_r[ch] <= (chan_sum[ch] > 12'd255) ? 8'hff : chan_sum[ch][7:0];
          end
          acc   <= prod_ext;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          rgba_r <= {alpha_prod[15:8], chan_r[2], chan_r[1], chan_r[0]};
          acc    <= acc + prod_ext;
          state  <= ST_SUM;
        end
        ST_SUM: begin
          acc   <= acc + prod_ext;
          state <= ST_ZCALC;
        end
        ST_ZCALC: begin
          if (z_wide > gfdt_pkg::Z_MAX) begin
            z_r <= 32'sh7fffffff;
          end else if (z_wide < gfdt_pkg::Z_MIN) begin
            z_r <= 32'sh80000000;
          end else begin
            z_r <= z_wide[31:0];
          end
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (slot_free) begin
            if (!depth_test_on || z_pass) begin
              out_x     <= x_r;
              out_y     <= y_r;
              out_color <= rgba_r;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Capture fragment fields and advance the multiplier
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r    <= frag.frag_x[7:0];
      y_r    <= frag.frag_y[7:0];
      cov_r  <= frag.coverage;
      w_r[0] <= frag.weight_a;
      w_r[1] <= frag.weight_b;
      w_r[2] <= frag.weight_c;
      idx_r  <= idx_full[gfdt_pkg::ZADDR_W-1:0];
    end
    prod <= mul_a * $signed({1'b0, mul_w});
  end

  assign pixel.valid       = out_valid;
  assign pixel.pixel_x     = out_x;
  assign pixel.pixel_y     = out_y;
  assign pixel.pixel_color = out_color;

endmodule

>>> tb/sv/tb_gouraud_fragment_depth_test_core.sv
// Testbench for gouraud_fragment_depth_test_core: shading, off-screen drop and depth test.
// It drives fragment requests, predicts pixel requests against its own copy of the depth
// store and compares them. Depends on gfdt_pkg, gfdt_frag_if and gfdt_pixel_if.
module tb_gouraud_fragment_depth_test_core;

  localparam int SCR_W = 256;
  localparam int SCR_H = 256;
  localparam int DRAIN_CYCLES = 16;
  // The clearing pass after reset alone moves no request for its whole length
  localparam int STALL_LIMIT = 262144;
  localparam int MAX_REPORTS = 40;
  localparam int PHASES = 8;
  localparam int PHASE_FRAGS = 145;
  localparam int W_ONE = 65536;
  localparam int W_MAX = 131071;
  localparam logic [31:0] DEPTH_MAXV = 32'h1FFF_FFFF;  // just under +8192.0
  localparam logic [31:0] DEPTH_MINV = 32'h2000_0000;  // -8192.0 in 30 bits

  typedef struct {
    logic signed [gfdt_pkg::POS_W-1:0] x;
    logic signed [gfdt_pkg::POS_W-1:0] y;
    logic [gfdt_pkg::COV_W-1:0]        cov;
    logic [gfdt_pkg::WEIGHT_W-1:0]     w [3];
  } frag_t;

  typedef struct {
    logic [gfdt_pkg::PIX_W-1:0]   px;
    logic [gfdt_pkg::PIX_W-1:0]   py;
    logic [gfdt_pkg::COLOR_W-1:0] color;
  } pixel_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [gfdt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gfdt_pkg::CFG_DATA_W-1:0] cfg_wdata;

  gfdt_frag_if  frag_ch();
  gfdt_pixel_if pixel_ch();

  gouraud_fragment_depth_test_core #(
    .SCREEN_WIDTH (SCR_W),
    .SCREEN_HEIGHT(SCR_H)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .frag     (frag_ch),
    .pixel    (pixel_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the registers and the depth store
  bit [gfdt_pkg::COLOR_W-1:0]         vert_color [3];
  bit signed [gfdt_pkg::VDEPTH_W-1:0] vert_depth [3];
  bit                                 depth_on;
  int                                 depth_mem [gfdt_pkg::ZENTRIES];
  pixel_t                             expected_pixels [$];

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int error_count;
  int frags_sent;
  int offscreen_sent;
  int pixels_checked;
  int depth_discards;
  int reg_writes;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Shade one fragment, run the depth test and queue the pixel it should produce
  function automatic void predict_pixel(input frag_t f);
    int unsigned q [3];
    int unsigned chan_sum;
    int unsigned cval;
    int v;
    int ch;
    logic [gfdt_pkg::COLOR_W-1:0] rgba;
    longint acc;
    longint z;
    int unsigned zidx;
    pixel_t pix;
    if (f.x < 0 || f.x >= SCR_W || f.y < 0 || f.y >= SCR_H) begin
      offscreen_sent++;
      return;
    end
    for (v = 0; v < 3; v++) q[v] = (int'(f.w[v]) * 255) >> 16;
    rgba = '0;
    for (ch = 0; ch < 4; ch++) begin
      chan_sum = 0;
      for (v = 0; v < 3; v++) begin
        cval = (vert_color[v] >> (8 * ch)) & 32'hFF;
        chan_sum += (cval * (q[v] + 1)) >> 8;
      end
      if (chan_sum > 255) chan_sum = 255;
      // alpha channel takes the coverage scale
      if (ch == 3) chan_sum = (chan_sum * (int'(f.cov) + 1)) >> 8;
      rgba[8*ch +: 8] = chan_sum[7:0];
    end
    if (depth_on) begin
      acc = 0;
      for (v = 0; v < 3; v++) acc += longint'(vert_depth[v]) * longint'(f.w[v]);
      // arithmetic shift floors toward minus infinity
      z = (acc >>> 16) - longint'(gfdt_pkg::DEPTH_OFFSET);
      if (z > longint'(gfdt_pkg::Z_MAX)) z = longint'(gfdt_pkg::Z_MAX);
      if (z < longint'(gfdt_pkg::Z_MIN)) z = longint'(gfdt_pkg::Z_MIN);
      zidx = (int'(f.y) * SCR_W + int'(f.x)) & (gfdt_pkg::ZENTRIES - 1);
      if (z >= longint'(depth_mem[zidx])) begin
        depth_discards++;
        return;
      end
      depth_mem[zidx] = int'(z);
    end
    pix.px    = f.x[gfdt_pkg::PIX_W-1:0];
    pix.py    = f.y[gfdt_pkg::PIX_W-1:0];
    pix.color = rgba;
    expected_pixels.insert(expected_pixels.size(), pix);
  endfunction

  function automatic frag_t make_frag(input int x, input int y, input int cov,
                                      input int wa, input int wb, input int wc);
    frag_t f;
    f.x    = 16'(x);
    f.y    = 16'(y);
    f.cov  = 8'(cov);
    f.w[0] = 17'(wa);
    f.w[1] = 17'(wb);
    f.w[2] = 17'(wc);
    return f;
  endfunction

  // On-screen fragment, mostly inside a small window so pixels repeat
  function automatic frag_t random_frag(input int win_x, input int win_y);
    frag_t f;
    int unsigned pick;
    int unsigned wa;
    int unsigned wb;
    int unsigned rot;
    int v;
    if ($urandom_range(9) < 7) begin
      f.x = 16'(win_x + int'($urandom_range(15)));
      f.y = 16'(win_y + int'($urandom_range(15)));
    end else begin
      f.x = 16'($urandom_range(SCR_W - 1));
      f.y = 16'($urandom_range(SCR_H - 1));
    end
    f.cov = 8'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 75) begin
      // weights that sum to one, in a random order
      wa  = $urandom_range(W_ONE);
      wb  = $urandom_range(W_ONE - wa);
      rot = $urandom_range(2);
      f.w[rot]           = 17'(wa);
      f.w[(rot + 1) % 3] = 17'(wb);
      f.w[(rot + 2) % 3] = 17'(W_ONE - wa - wb);
    end else if (pick < 85) begin
      for (v = 0; v < 3; v++) begin
        case ($urandom_range(2))
          0:       f.w[v] = '0;
          1:       f.w[v] = 17'(W_ONE);
          default: f.w[v] = 17'(W_MAX);
        endcase
      end
    end else begin
      for (v = 0; v < 3; v++) f.w[v] = 17'($urandom_range(W_MAX));
    end
    return f;
  endfunction

  // Arbitrary position, almost always off screen
  function automatic frag_t noise_frag();
    return make_frag($urandom(), $urandom(), $urandom_range(255),
                     $urandom_range(W_MAX), $urandom_range(W_MAX), $urandom_range(W_MAX));
  endfunction

  // Write one register; call and return just after a falling edge
  task automatic write_reg(input gfdt_pkg::cfg_idx_t idx,
                           input logic [gfdt_pkg::CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(posedge clk);
    case (idx)
      gfdt_pkg::CFG_COLOR_V0: vert_color[0] = data;
      gfdt_pkg::CFG_COLOR_V1: vert_color[1] = data;
      gfdt_pkg::CFG_COLOR_V2: vert_color[2] = data;
      gfdt_pkg::CFG_DEPTH_V0: vert_depth[0] = data[gfdt_pkg::VDEPTH_W-1:0];
      gfdt_pkg::CFG_DEPTH_V1: vert_depth[1] = data[gfdt_pkg::VDEPTH_W-1:0];
      gfdt_pkg::CFG_DEPTH_V2: vert_depth[2] = data[gfdt_pkg::VDEPTH_W-1:0];
      gfdt_pkg::CFG_DEPTH_ON: depth_on = data[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_setup(input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] c2, input logic [31:0] d0,
                            input logic [31:0] d1, input logic [31:0] d2,
                            input logic [31:0] on);
    write_reg(gfdt_pkg::CFG_COLOR_V0, c0);
    write_reg(gfdt_pkg::CFG_COLOR_V1, c1);
    write_reg(gfdt_pkg::CFG_COLOR_V2, c2);
    write_reg(gfdt_pkg::CFG_DEPTH_V0, d0);
    write_reg(gfdt_pkg::CFG_DEPTH_V1, d1);
    write_reg(gfdt_pkg::CFG_DEPTH_V2, d2);
    write_reg(gfdt_pkg::CFG_DEPTH_ON, on);
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // Offer one fragment request and hold it until taken
  task automatic send_frag(input frag_t f);
    while ($urandom_range(99) < src_idle_pct) begin
      frag_ch.valid = 1'b0;
      @(negedge clk);
    end
    frag_ch.valid    = 1'b1;
    frag_ch.frag_x   = f.x;
    frag_ch.frag_y   = f.y;
    frag_ch.coverage = f.cov;
    frag_ch.weight_a = f.w[0];
    frag_ch.weight_b = f.w[1];
    frag_ch.weight_c = f.w[2];
    @(posedge clk);
    while (!frag_ch.ready) @(posedge clk);
    frags_sent++;
    predict_pixel(f);
    @(negedge clk);
    frag_ch.valid = 1'b0;
  endtask

  // Wait for every queued pixel, then let a discarded fragment finish
  task automatic drain_pipe();
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Channel extremes, weights above one, zero weights and off-screen drops
  task automatic test_shading_extremes();
    set_idling(0, 0);
    load_setup(32'hFFFF_FFFF, 32'h8040_01FF, 32'h00FF_7F10,
               DEPTH_MAXV, DEPTH_MINV, 32'h0, 32'h0);
    send_frag(make_frag(0, 0, 255, W_ONE, 0, 0));
    send_frag(make_frag(255, 255, 0, 0, W_ONE, 0));
    send_frag(make_frag(255, 0, 128, 0, 0, W_ONE));
    send_frag(make_frag(0, 255, 255, 21845, 21845, 21846));
    send_frag(make_frag(10, 20, 255, W_MAX, W_MAX, W_MAX));
    send_frag(make_frag(100, 100, 0, 0, 0, 0));
    send_frag(make_frag(-1, 5, 255, W_ONE, 0, 0));
    send_frag(make_frag(256, 5, 255, W_ONE, 0, 0));
    send_frag(make_frag(5, -1, 255, W_ONE, 0, 0));
    send_frag(make_frag(5, 256, 255, W_ONE, 0, 0));
    send_frag(make_frag(-32768, 32767, 255, W_MAX, W_MAX, W_MAX));
    send_frag(make_frag(32767, -32768, 0, 0, 0, 0));
    send_frag(make_frag(128, 64, 1, 65535, 1, 0));
  endtask

  // Strictly-less test, equal depth, positive depth and both saturation limits
  task automatic test_depth_rules();
    drain_pipe();
    set_idling(21, 21);
    load_setup(32'h1234_5678, 32'hA5C3_0F96, 32'h7F80_01FE,
               DEPTH_MINV, DEPTH_MINV, DEPTH_MAXV, 32'h1);
    send_frag(make_frag(7, 9, 200, 0, 0, W_ONE));
    send_frag(make_frag(7, 9, 200, 0, 0, W_ONE));
    send_frag(make_frag(7, 9, 17, W_ONE, 0, 0));
    send_frag(make_frag(7, 9, 17, 0, 0, W_ONE));
    send_frag(make_frag(200, 3, 255, W_MAX, W_MAX, 0));
    send_frag(make_frag(200, 3, 255, W_MAX, W_MAX, 0));
    send_frag(make_frag(201, 3, 255, 0, 0, W_MAX));
    send_frag(make_frag(-5, 3, 255, W_ONE, 0, 0));
    send_frag(make_frag(255, 255, 255, 21845, 21845, 21846));
    drain_pipe();
    load_setup(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
               DEPTH_MAXV, DEPTH_MAXV, DEPTH_MAXV, 32'h1);
    send_frag(make_frag(0, 0, 255, W_MAX, W_MAX, W_MAX));
    send_frag(make_frag(0, 0, 255, 0, 0, 0));
  endtask

  // Random fragments across idling phases and register settings, with noise
  task automatic test_random_traffic();
    int phase;
    int n;
    int win_x;
    int win_y;
    frag_t f;
    for (phase = 0; phase < PHASES; phase++) begin
      drain_pipe();
      case (phase % 4)
        0:       set_idling(0, 0);
        1:       set_idling(79, 0);
        2:       set_idling(0, 79);
        default: set_idling(21, 21);
      endcase
      if (phase == 0) begin
        load_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   DEPTH_MAXV, DEPTH_MAXV, DEPTH_MAXV, 32'h1);
      end else if (phase == 1) begin
        load_setup(32'h0, 32'h0, 32'h0, DEPTH_MINV, DEPTH_MINV, DEPTH_MINV, 32'h0);
      end else begin
        load_setup($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   ($urandom() & 32'hFFFF_FFFE) | (phase % 2));
      end
      win_x = $urandom_range(SCR_W - 16);
      win_y = $urandom_range(SCR_H - 16);
      n = 0;
      while (n < PHASE_FRAGS) begin
        if ($urandom_range(9) == 0) begin
          f = noise_frag();
        end else begin
          f = random_frag(win_x, win_y);
          n++;
        end
        send_frag(f);
      end
    end
    drain_pipe();
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    pixel_ch.ready = ($urandom_range(99) >= snk_stall_pct);
  end

  // Compare each accepted pixel request with the oldest expectation
  always @(posedge clk) begin : check_pixels
    pixel_t exp_pix;
    if (!rst && pixel_ch.valid && pixel_ch.ready) begin
      pixels_checked++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel (%0d,%0d) color %h with nothing expected",
                                  pixel_ch.pixel_x, pixel_ch.pixel_y, pixel_ch.pixel_color));
      end else begin
        exp_pix = expected_pixels.pop_front();
        if (pixel_ch.pixel_x !== exp_pix.px)
          report_mismatch($sformatf("pixel_x got %0d want %0d", pixel_ch.pixel_x, exp_pix.px));
        if (pixel_ch.pixel_y !== exp_pix.py)
          report_mismatch($sformatf("pixel_y got %0d want %0d", pixel_ch.pixel_y, exp_pix.py));
        if (pixel_ch.pixel_color !== exp_pix.color)
          report_mismatch($sformatf("pixel_color at (%0d,%0d) got %h want %h", exp_pix.px,
                                    exp_pix.py, pixel_ch.pixel_color, exp_pix.color));
      end
    end
  end

  // Drop the run when no request moves for too long
  always @(posedge clk) begin
    if ((frag_ch.valid && frag_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", idle_cycles);
      $display("tb_gouraud_fragment_depth_test_core failed");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = gfdt_pkg::CFG_COLOR_V0;
    cfg_wdata        = '0;
    frag_ch.valid    = 1'b0;
    frag_ch.frag_x   = '0;
    frag_ch.frag_y   = '0;
    frag_ch.coverage = '0;
    frag_ch.weight_a = '0;
    frag_ch.weight_b = '0;
    frag_ch.weight_c = '0;
    pixel_ch.ready   = 1'b0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    error_count      = 0;
    frags_sent       = 0;
    offscreen_sent   = 0;
    pixels_checked   = 0;
    depth_discards   = 0;
    reg_writes       = 0;
    idle_cycles      = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_shading_extremes();
    test_depth_rules();
    test_random_traffic();

    while (expected_pixels.size() != 0) begin
      void'(expected_pixels.pop_front());
      report_mismatch("expected pixel never arrived");
    end
    $display("covered %0d fragments (%0d off screen), %0d register writes, %0d idling phases",
             frags_sent, offscreen_sent, reg_writes, PHASES);
    $display("checked %0d pixel requests, %0d depth-test discards, %0d mismatches",
             pixels_checked, depth_discards, error_count);
    if (error_count == 0) begin
      $display("tb_gouraud_fragment_depth_test_core passed");
    end else begin
      $display("tb_gouraud_fragment_depth_test_core failed");
    end
    $finish;
  end

endmodule
